### design/mpq_pkg.sv
// Package for the min priority queue: shared types and command codes.
// Depends on nothing; every other design file refers to it by scoped names.
`default_nettype none

package mpq_pkg;

	localparam int TagW  = 16;
	localparam int KeyW  = 16;
	localparam int FillW = 7;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	typedef logic [TagW-1:0]  tag_t;
	typedef logic [KeyW-1:0]  key_t;
	typedef logic [FillW-1:0] fill_t;

	typedef struct packed {
		tag_t tag;
		key_t key;
	} pair_t;

	// Broadcast from the top level to every cell in the row.
	typedef struct packed {
		logic  enq;
		logic  deq;
		pair_t pair;
	} cell_ctrl_t;

endpackage

`default_nettype wire

### design/mpq_if.sv
// Valid/ready channel interfaces for the min priority queue.
// Depends on mpq_pkg for the payload types.
`default_nettype none

interface mpq_in_if;
	logic              valid;
	logic              ready;
	logic              cmd;
	mpq_pkg::tag_t     item_tag;
	mpq_pkg::key_t     item_key;

	modport source (output valid, output cmd, output item_tag, output item_key, input ready);
	modport sink   (input valid, input cmd, input item_tag, input item_key, output ready);
endinterface

interface mpq_out_if;
	logic              valid;
	logic              ready;
	logic              ok;
	mpq_pkg::tag_t     out_tag;
	mpq_pkg::key_t     out_key;
	mpq_pkg::fill_t    fill_count;

	modport source (output valid, output ok, output out_tag, output out_key,
		output fill_count, input ready);
	modport sink   (input valid, input ok, input out_tag, input out_key,
		input fill_count, output ready);
endinterface

`default_nettype wire

### design/mpq_cell.sv
// One cell of the sorted shift row: holds a single (tag, key) pair.
// Depends on mpq_pkg for the pair and control types.
`default_nettype none

module mpq_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  mpq_pkg::cell_ctrl_t ctrl,
	input  wire                 valid,
	input  wire                 left_flag,
	input  mpq_pkg::pair_t      left_pair,
	input  mpq_pkg::pair_t      right_pair,
	output mpq_pkg::pair_t      pair,
	output logic                flag
);

	mpq_pkg::pair_t pair_q;

	// New pair belongs at or above this cell; ties put the newest pair nearer the head.
	assign flag = !valid || (ctrl.pair.key <= pair_q.key);
	assign pair = pair_q;

	// Payload only; occupancy lives in the top level's count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= '0;
		end else if (ctrl.enq && flag) begin
			pair_q <= left_flag ? left_pair : ctrl.pair;
		end else if (ctrl.deq) begin
			pair_q <= right_pair;
		end
	end

endmodule

`default_nettype wire

### design/min_priority_queue_core.sv
// Min priority queue of (tag, key) pairs built as a row of sorting cells.
// Uses mpq_pkg, the channel interfaces in mpq_if and the cell in mpq_cell.
//
// Usage:
//   in_ch carries words of (cmd, item_tag, item_key): cmd 0 inserts the pair,
//   cmd 1 removes the pair with the smallest key (among equal keys, the one
//   inserted last). out_ch returns one word per input word: ok, the removed
//   tag and key (zero unless a removal succeeded) and the fill count after
//   the operation. An insert into a full queue or a removal from an empty
//   queue returns ok = 0 and leaves the contents as they were.
//   The result word is registered and appears in the cycle after input
//   acceptance; one word is taken every cycle unless the receiver stalls.
//   Every cell compares the new key against its own and looks only at its
//   neighbors, so all cells update in parallel regardless of CAPACITY.
//   A one-word output register decouples the sides: while the receiver
//   stalls, at most one result is held and input is taken only when that
//   register is free or being drained in the same cycle.
//   Reset empties the queue at once; no clearing pass is needed.
`default_nettype none

module min_priority_queue_core #(
	parameter int CAPACITY = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	mpq_in_if.sink      in_ch,
	mpq_out_if.source   out_ch
);

	localparam int CntW = $clog2(CAPACITY + 1);

	logic [CntW-1:0]      count_q;
	logic [CntW-1:0]      count_next;
	logic                 accept;
	logic                 is_enq;
	logic                 is_deq;
	logic                 enq_ok;
	logic                 deq_ok;
	mpq_pkg::cell_ctrl_t  ctrl;
	mpq_pkg::pair_t       pair_w [CAPACITY];
	logic                 flag_w [CAPACITY];

	logic                 out_valid_q;
	logic                 ok_q;
	mpq_pkg::pair_t       res_q;
	mpq_pkg::fill_t       fill_q;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	assign is_enq = (in_ch.cmd == mpq_pkg::CMD_ENQ);
	assign is_deq = (in_ch.cmd == mpq_pkg::CMD_DEQ);
	assign enq_ok = is_enq && (count_q != CntW'(CAPACITY));
	assign deq_ok = is_deq && (count_q != '0);

	assign ctrl.enq      = accept && enq_ok;
	assign ctrl.deq      = accept && deq_ok;
	assign ctrl.pair.tag = in_ch.item_tag;
	assign ctrl.pair.key = in_ch.item_key;

	always_comb begin
		count_next = count_q;
		if (enq_ok) begin
			count_next = count_q + CntW'(1);
		end else if (deq_ok) begin
			count_next = count_q - CntW'(1);
		end
	end

	// Cell 0 is the head; cells shift toward the tail on insert, toward the head on removal.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic           valid_c;
		logic           left_flag_c;
		mpq_pkg::pair_t left_pair_c;
		mpq_pkg::pair_t right_pair_c;

		assign valid_c = (CntW'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_flag_c = 1'b0;
			assign left_pair_c = ctrl.pair;
		end else begin : g_body
			assign left_flag_c = flag_w[i-1];
			assign left_pair_c = pair_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_pair_c = pair_w[i];
		end else begin : g_inner
			assign right_pair_c = pair_w[i+1];
		end

		mpq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.valid      (valid_c),
			.left_flag  (left_flag_c),
			.left_pair  (left_pair_c),
			.right_pair (right_pair_c),
			.pair       (pair_w[i]),
			.flag       (flag_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q   <= enq_ok || deq_ok;
			res_q  <= deq_ok ? pair_w[0] : '0;
			fill_q <= mpq_pkg::FillW'(count_next);
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.ok         = ok_q;
	assign out_ch.out_tag    = res_q.tag;
	assign out_ch.out_key    = res_q.key;
	assign out_ch.fill_count = fill_q;

endmodule

`default_nettype wire
